// File: design/vmalu_pkg.sv
// shared types and constants for the vm integer alu with branch
// operation codes, error codes, queue entry layout and channel widths
// no dependencies
package vmalu_pkg;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 56;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS   = 32;
   localparam int DCNT_BITS   = $clog2(DIV_STEPS + 1);

   typedef enum logic [4:0] {
      OP_ADD       = 5'd0,
      OP_SUB       = 5'd1,
      OP_MUL       = 5'd2,
      OP_DIV       = 5'd3,
      OP_MOD       = 5'd4,
      OP_AND       = 5'd5,
      OP_OR        = 5'd6,
      OP_XOR       = 5'd7,
      OP_LSH       = 5'd8,
      OP_RSH       = 5'd9,
      OP_INC       = 5'd10,
      OP_DEC       = 5'd11,
      OP_NOT       = 5'd12,
      OP_COMPL     = 5'd13,
      OP_NEG       = 5'd14,
      OP_LT        = 5'd15,
      OP_GT        = 5'd16,
      OP_LTE       = 5'd17,
      OP_GTE       = 5'd18,
      OP_EQ        = 5'd19,
      OP_NEQ       = 5'd20,
      OP_LOADCONST = 5'd21,
      OP_LOADNULL  = 5'd22,
      OP_JZ        = 5'd23,
      OP_JNZ       = 5'd24,
      OP_JMP       = 5'd25,
      OP_MOVE      = 5'd26
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DIV_ZERO = 2'd1,
      ERR_UNKNOWN  = 2'd2
   } err_type;

   // one decoded instruction as it sits in the queue
   typedef struct packed {
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
      logic [15:0] target;
      err_type     err;
      logic        div_go;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: design/vmalu_front.sv
// front end: takes request words, decodes and classifies them, pushes to the queue
// depends on vmalu_pkg
module vmalu_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // func[4:0], operand_a[36:5], operand_b[68:37], jump_target[84:69]
   input  logic [vmalu_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  vmalu_pkg::q_status_type           q_stat,
   output logic                              push,
   output vmalu_pkg::cmd_type                cmd
);

   logic [4:0]  func;
   logic [31:0] opa;
   logic [31:0] opb;
   logic        is_divmod;
   logic        is_unknown;
   logic        b_zero;

   assign func       = req_tdata[4:0];
   assign opa        = req_tdata[36:5];
   assign opb        = req_tdata[68:37];
   assign is_divmod  = (func == vmalu_pkg::OP_DIV) || (func == vmalu_pkg::OP_MOD);
   assign is_unknown = func > vmalu_pkg::OP_MOVE;
   assign b_zero     = opb == 32'd0;

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && !q_stat.full;

   always_comb begin
      cmd.op     = vmalu_pkg::op_type'(func);
      cmd.a      = opa;
      cmd.b      = opb;
      cmd.target = req_tdata[84:69];
      cmd.div_go = is_divmod && !b_zero;
      priority if (is_unknown) begin
         cmd.err = vmalu_pkg::ERR_UNKNOWN;
      end else if (is_divmod && b_zero) begin
         cmd.err = vmalu_pkg::ERR_DIV_ZERO;
      end else begin
         cmd.err = vmalu_pkg::ERR_NONE;
      end
   end

endmodule

// File: design/vmalu_fifo.sv
// small queue of decoded instructions between front and back
// depends on vmalu_pkg
module vmalu_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  vmalu_pkg::cmd_type       din,
   input  logic                     pop,
   output vmalu_pkg::cmd_type       dout,
   output vmalu_pkg::q_status_type  q_stat
);

   vmalu_pkg::cmd_type                entry_ff [vmalu_pkg::QUEUE_DEPTH];
   logic [vmalu_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [vmalu_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [vmalu_pkg::QCNT_BITS-1:0]   count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign q_stat.full  = count_ff == vmalu_pkg::QCNT_BITS'(vmalu_pkg::QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign dout         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + vmalu_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + vmalu_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + vmalu_pkg::QCNT_BITS'(do_push) - vmalu_pkg::QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: design/vmalu_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on vmalu_pkg
module vmalu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   input  logic        is_mod,
   output logic        busy,
   output logic [31:0] result
);

   logic [vmalu_pkg::DCNT_BITS-1:0] count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic        mod_ff, mod_in;
   logic [32:0] trial;
   logic [31:0] sel;

   assign busy  = count_ff != '0;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
   assign sel   = mod_ff ? rem_ff : quo_ff;
   // remainder follows the dividend sign, quotient the xor of both signs
   assign result = neg_ff ? 32'd0 - sel : sel;

   always_comb begin
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      neg_in   = neg_ff;
      mod_in   = mod_ff;
      if (start) begin
         count_in = vmalu_pkg::DCNT_BITS'(vmalu_pkg::DIV_STEPS);
         rem_in   = '0;
         quo_in   = dividend[31] ? 32'd0 - dividend : dividend;
         dsr_in   = divisor[31] ? 32'd0 - divisor : divisor;
         neg_in   = is_mod ? dividend[31] : dividend[31] ^ divisor[31];
         mod_in   = is_mod;
      end else if (busy) begin
         count_in = count_ff - vmalu_pkg::DCNT_BITS'(1);
         rem_in   = trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];
         quo_in   = {quo_ff[30:0], !trial[32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
      mod_ff <= mod_in;
   end

endmodule

// File: design/vmalu_back.sv
// back end: executes queued instructions, holds zero flag and instruction pointer,
// drives the registered result word; depends on vmalu_pkg and vmalu_div
module vmalu_back #(
   parameter int ADDR_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vmalu_pkg::cmd_type                head,
   input  logic                              head_valid,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_value[31:0], writes_result[32], zero_flag_out[33],
   // next_address[49:34], error_code[51:50]
   output logic [vmalu_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_EXEC = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic                  zf_ff, zf_in;
   logic [ADDR_BITS-1:0]  ip_ff, ip_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [vmalu_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  div_start;
   logic                  div_busy;
   logic [31:0]           div_result;
   logic                  emit;

   logic [31:0]           alu_res;
   logic                  alu_wr;
   logic                  alu_flag;
   logic                  alu_jump;
   logic [31:0]           res;
   logic                  wr;
   logic                  flag_upd;
   logic                  advance;
   logic                  jump;
   vmalu_pkg::err_type    err;
   logic [4:0]            sh;
   logic [31:0]           mul_lo;
   logic                  lt_ab;
   logic                  lt_ba;
   logic [ADDR_BITS+15:0] tgt_wide;
   logic [ADDR_BITS+15:0] ip_wide;

   vmalu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head.a),
      .divisor  (head.b),
      .is_mod   (head.op == vmalu_pkg::OP_MOD),
      .busy     (div_busy),
      .result   (div_result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sh       = head.b[4:0];
   assign mul_lo   = head.a * head.b;
   assign lt_ab    = $signed(head.a) < $signed(head.b);
   assign lt_ba    = $signed(head.b) < $signed(head.a);
   assign tgt_wide = {{ADDR_BITS{1'b0}}, head.target};

   // operations other than div and mod, computed combinationally from the queue head
   always_comb begin
      alu_res  = '0;
      alu_wr   = 1'b1;
      alu_flag = 1'b1;
      alu_jump = 1'b0;
      unique case (head.op)
         vmalu_pkg::OP_ADD:       alu_res = head.a + head.b;
         vmalu_pkg::OP_SUB:       alu_res = head.a - head.b;
         vmalu_pkg::OP_MUL:       alu_res = mul_lo;
         vmalu_pkg::OP_AND:       alu_res = head.a & head.b;
         vmalu_pkg::OP_OR:        alu_res = head.a | head.b;
         vmalu_pkg::OP_XOR:       alu_res = head.a ^ head.b;
         vmalu_pkg::OP_LSH:       alu_res = head.a << sh;
         vmalu_pkg::OP_RSH:       alu_res = $unsigned($signed(head.a) >>> sh);
         vmalu_pkg::OP_INC:       alu_res = head.a + 32'd1;
         vmalu_pkg::OP_DEC:       alu_res = head.a - 32'd1;
         vmalu_pkg::OP_NOT:       alu_res = {31'd0, head.a == 32'd0};
         vmalu_pkg::OP_COMPL:     alu_res = ~head.a;
         vmalu_pkg::OP_NEG:       alu_res = 32'd0 - head.a;
         vmalu_pkg::OP_LT:        alu_res = {31'd0, lt_ab};
         vmalu_pkg::OP_GT:        alu_res = {31'd0, lt_ba};
         vmalu_pkg::OP_LTE:       alu_res = {31'd0, !lt_ba};
         vmalu_pkg::OP_GTE:       alu_res = {31'd0, !lt_ab};
         vmalu_pkg::OP_EQ:        alu_res = {31'd0, head.a == head.b};
         vmalu_pkg::OP_NEQ:       alu_res = {31'd0, head.a != head.b};
         vmalu_pkg::OP_LOADCONST: alu_res = head.a;
         vmalu_pkg::OP_LOADNULL:  alu_res = '0;
         vmalu_pkg::OP_JZ: begin
            alu_wr   = 1'b0;
            alu_flag = 1'b0;
            alu_jump = zf_ff;
         end
         vmalu_pkg::OP_JNZ: begin
            alu_wr   = 1'b0;
            alu_flag = 1'b0;
            alu_jump = !zf_ff;
         end
         vmalu_pkg::OP_JMP: begin
            alu_wr   = 1'b0;
            alu_flag = 1'b0;
            alu_jump = 1'b1;
         end
         vmalu_pkg::OP_MOVE: begin
            alu_res  = head.a;
            alu_flag = 1'b0;
         end
         // div and mod reach here only with an error, unknown codes likewise
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      emit      = 1'b0;
      res       = alu_res;
      wr        = alu_wr;
      flag_upd  = alu_flag;
      jump      = alu_jump;
      advance   = !alu_jump;
      err       = head.err;
      unique case (state_ff)
         ST_EXEC: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               if (head.div_go) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  emit = 1'b1;
               end
            end
            if (head.err != vmalu_pkg::ERR_NONE) begin
               res      = '0;
               wr       = 1'b0;
               flag_upd = 1'b0;
               jump     = 1'b0;
               advance  = 1'b0;
            end
         end
         ST_DIV: begin
            res      = div_result;
            wr       = 1'b1;
            flag_upd = 1'b1;
            jump     = 1'b0;
            advance  = 1'b1;
            err      = vmalu_pkg::ERR_NONE;
            if (!div_busy && out_free) begin
               emit     = 1'b1;
               state_in = ST_EXEC;
            end
         end
         default: state_in = ST_EXEC;
      endcase
   end

   always_comb begin
      zf_in = zf_ff;
      ip_in = ip_ff;
      if (emit) begin
         if (flag_upd) begin
            zf_in = res == 32'd0;
         end
         priority if (jump) begin
            ip_in = tgt_wide[ADDR_BITS-1:0];
         end else if (advance) begin
            ip_in = ip_ff + ADDR_BITS'(1);
         end else begin
            ip_in = ip_ff;
         end
      end
   end

   assign ip_wide = {16'd0, ip_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'd0, err, ip_wide[15:0], zf_in, wr, res};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXEC;
         zf_ff        <= 1'b0;
         ip_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zf_ff        <= zf_in;
         ip_ff        <= ip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/vm_integer_alu_with_branch.sv
// top level of the vm integer alu with branch: front decode, instruction queue, back execute
// depends on vmalu_pkg, vmalu_front, vmalu_fifo, vmalu_back
//
// Executes one virtual-machine instruction per request word and returns one
// response word for each, in order. A decode stage accepts words into a four-entry
// queue, so requests keep flowing while a response waits to be taken. All operations
// except div and mod with a nonzero divisor are computed combinationally, sustaining
// one word per clock while responses are taken. div and mod with a nonzero divisor go
// through a shared restoring divider that retires one quotient bit per cycle, in an
// issue step, the iterations and a result step, during which later words queue up.
// Zero flag and instruction pointer reset to zero; no clearing pass is needed.
module vm_integer_alu_with_branch #(
   parameter int ADDR_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // func[4:0], operand_a[36:5], operand_b[68:37], jump_target[84:69]
   input  logic [vmalu_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_value[31:0], writes_result[32], zero_flag_out[33],
   // next_address[49:34], error_code[51:50]
   output logic [vmalu_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   vmalu_pkg::cmd_type      front_cmd;
   vmalu_pkg::cmd_type      head_cmd;
   vmalu_pkg::q_status_type q_stat;
   logic                    push;
   logic                    pop;

   vmalu_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .cmd        (front_cmd)
   );

   vmalu_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .din    (front_cmd),
      .pop    (pop),
      .dout   (head_cmd),
      .q_stat (q_stat)
   );

   vmalu_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .head_valid (!q_stat.empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: design/vmalu_checker.sv
// port-level checks on the vm integer alu with branch, attached by bind
// depends on vmalu_pkg
module vmalu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vmalu_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a failed instruction writes nothing and returns zero
   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[51:50] != vmalu_pkg::ERR_NONE
      |-> !rsp_tdata[32] && rsp_tdata[31:0] == 32'd0)
      else $error("error response writes or carries a value");

   // the unused error code and the pad bits stay clear
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[51:50] != 2'd3 && rsp_tdata[55:52] == 4'd0)
      else $error("bad error code or pad bits in response");

endmodule

bind vm_integer_alu_with_branch vmalu_checker u_vmalu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
